/* design/rxaf_pkg.sv */
package rxaf_pkg;

  localparam int AddrW = 3;
  localparam int PosW  = 6;

  localparam logic [PosW-1:0] POS_MAX   = 6'd63;
  localparam logic [PosW-1:0] MIN_FRAME = 6'd42;

  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

  // byte offsets from the start of the destination MAC
  localparam logic [PosW-1:0] OFS_TYPE_HI = 6'd12;
  localparam logic [PosW-1:0] OFS_TYPE_LO = 6'd13;
  localparam logic [PosW-1:0] OFS_OP_HI   = 6'd20;
  localparam logic [PosW-1:0] OFS_OP_LO   = 6'd21;
  localparam logic [PosW-1:0] OFS_SHA_LO  = 6'd22;
  localparam logic [PosW-1:0] OFS_PROTO   = 6'd23;
  localparam logic [PosW-1:0] OFS_SHA_HI  = 6'd27;
  localparam logic [PosW-1:0] OFS_GW_LO   = 6'd28;
  localparam logic [PosW-1:0] OFS_GW_HI   = 6'd31;
  localparam logic [PosW-1:0] OFS_LOC_LO  = 6'd30;
  localparam logic [PosW-1:0] OFS_LOC_HI  = 6'd33;
  localparam logic [PosW-1:0] OFS_ICMP_T  = 6'd34;
  localparam logic [PosW-1:0] OFS_ID_HI   = 6'd38;
  localparam logic [PosW-1:0] OFS_ID_LO   = 6'd39;

  localparam logic [7:0] ARP_OP_HI  = 8'h00;
  localparam logic [7:0] ARP_OP_LO  = 8'h02;
  localparam logic [7:0] IP_PROTO_ICMP = 8'h01;
  localparam logic [7:0] ICMP_ECHO_REPLY = 8'h00;
  localparam logic [7:0] ECHO_ID_HI = 8'h4D;
  localparam logic [7:0] ECHO_ID_LO = 8'h4F;

  localparam logic [31:0] LOCAL_RESET   = 32'h0A00_020F;
  localparam logic [31:0] GATEWAY_RESET = 32'h0A00_0202;

  // match flag bit positions
  localparam int F_OP_HI  = 0;
  localparam int F_OP_LO  = 1;
  localparam int F_GW_IP  = 2;
  localparam int F_PROTO  = 3;
  localparam int F_LOC_IP = 4;
  localparam int F_ICMP_T = 5;
  localparam int F_ID_HI  = 6;
  localparam int F_ID_LO  = 7;

  typedef enum logic [0:0] {
    REG_LOCAL   = 1'b0,
    REG_GATEWAY = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE       = 2'd0,
    KIND_ARP_REPLY  = 2'd1,
    KIND_ECHO_REPLY = 2'd2
  } frame_kind_t;

  typedef struct packed {
    logic [31:0] local_addr;
    logic [31:0] gateway_addr;
  } cfg_t;

  function automatic logic [7:0] ip_octet(input logic [31:0] addr, input logic [1:0] k);
    logic [7:0] o;
    case (k)
      2'd0:    o = addr[31:24];
      2'd1:    o = addr[23:16];
      2'd2:    o = addr[15:8];
      default: o = addr[7:0];
    endcase
    return o;
  endfunction

endpackage

/* design/rx_frame_arp_icmp_filter_core.sv */
// Receive filter that learns the gateway MAC and spots ICMP echo replies.
//
// Input channel: one frame byte per beat (rx_byte) with end_of_frame set on
// the final byte, handshaked by in_valid / in_ready. Bytes count from the
// first byte of the destination MAC.
// Output channel: one result beat per frame, on out_valid / out_ready,
// carrying frame_kind and the current gateway MAC, gateway_valid and
// echo_seen. Non-final bytes produce no result.
// The result of a frame is registered and presented in the cycle after its
// final byte is accepted. Throughput is one byte per cycle while no result
// is held by a stalled receiver; each byte runs field compares and a counter update.
// Local and gateway IPv4 addresses are set over the APB port (offset 0x0
// and 0x4); the user must write them only while the block is idle, it does not enforce this.
// Reset clears the byte counter, the captured fields, the learned MAC and
// both sticky flags, and loads the default addresses 10.0.2.15 / 10.0.2.2.
// When the receiver stalls, the pending result holds; non-final bytes and a
// new final byte are accepted once that result has been taken (or in the
// cycle it is taken).
module rx_frame_arp_icmp_filter_core
  import rxaf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       rx_byte,
  input  logic             end_of_frame,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       frame_kind,
  output logic [47:0]      gateway_hw_address,
  output logic             gateway_valid,
  output logic             echo_seen
);

  cfg_t cfg;

  rxaf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [PosW-1:0] pos, pos_next;
  logic [15:0]     ether_kind, ether_kind_next;
  logic [7:0]      flags, flags_next;
  logic [47:0]     sha, sha_next;
  logic [47:0]     gw_mac, gw_mac_next;
  logic            gw_known, gw_known_next;
  logic            echo_flag, echo_flag_next;
  frame_kind_t     kind, kind_next;
  logic            accept;
  logic [PosW-1:0] gw_rel, loc_rel;
  logic            arp_ok, echo_ok;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign gw_rel   = pos - OFS_GW_LO;
  assign loc_rel  = pos - OFS_LOC_LO;

  always_comb begin
    pos_next        = pos;
    ether_kind_next = ether_kind;
    flags_next      = flags;
    sha_next        = sha;
    gw_mac_next     = gw_mac;
    gw_known_next   = gw_known;
    echo_flag_next  = echo_flag;
    kind_next       = KIND_NONE;
    arp_ok          = 1'b0;
    echo_ok         = 1'b0;

    if (pos != POS_MAX) begin
      pos_next = pos + 1'b1;
      case (pos)
        OFS_TYPE_HI: ether_kind_next[15:8]  = rx_byte;
        OFS_TYPE_LO: ether_kind_next[7:0]   = rx_byte;
        OFS_OP_HI:   flags_next[F_OP_HI]  = (rx_byte == ARP_OP_HI);
        OFS_OP_LO:   flags_next[F_OP_LO]  = (rx_byte == ARP_OP_LO);
        OFS_PROTO:   flags_next[F_PROTO]  = (rx_byte == IP_PROTO_ICMP);
        OFS_ICMP_T:  flags_next[F_ICMP_T] = (rx_byte == ICMP_ECHO_REPLY);
        OFS_ID_HI:   flags_next[F_ID_HI]  = (rx_byte == ECHO_ID_HI);
        OFS_ID_LO:   flags_next[F_ID_LO]  = (rx_byte == ECHO_ID_LO);
        default: ;
      endcase
      if (pos inside {[OFS_SHA_LO:OFS_SHA_HI]})
        sha_next = {sha[39:0], rx_byte};
      // running four-byte compares: the first byte restarts, later bytes can only clear
      if (pos inside {[OFS_GW_LO:OFS_GW_HI]}) begin
        if (rx_byte != ip_octet(cfg.gateway_addr, gw_rel[1:0]))
          flags_next[F_GW_IP] = 1'b0;
        else if (pos == OFS_GW_LO)
          flags_next[F_GW_IP] = 1'b1;
      end
      if (pos inside {[OFS_LOC_LO:OFS_LOC_HI]}) begin
        if (rx_byte != ip_octet(cfg.local_addr, loc_rel[1:0]))
          flags_next[F_LOC_IP] = 1'b0;
        else if (pos == OFS_LOC_LO)
          flags_next[F_LOC_IP] = 1'b1;
      end
    end

    if (pos_next >= MIN_FRAME) begin
      arp_ok  = (ether_kind_next == ETYPE_ARP) && flags_next[F_OP_HI] &&
                flags_next[F_OP_LO] && flags_next[F_GW_IP];
      echo_ok = (ether_kind_next == ETYPE_IPV4) && flags_next[F_PROTO] &&
                flags_next[F_LOC_IP] && flags_next[F_ICMP_T] &&
                flags_next[F_ID_HI] && flags_next[F_ID_LO];
    end

    if (end_of_frame) begin
      if (arp_ok) begin
        gw_mac_next   = sha_next;
        gw_known_next = 1'b1;
        kind_next     = KIND_ARP_REPLY;
      end else if (echo_ok) begin
        echo_flag_next = 1'b1;
        kind_next      = KIND_ECHO_REPLY;
      end
      // drop the per-frame capture
      pos_next        = '0;
      ether_kind_next = '0;
      flags_next      = '0;
      sha_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      ether_kind <= '0;
      flags      <= '0;
      sha        <= '0;
      gw_mac     <= '0;
      gw_known   <= 1'b0;
      echo_flag  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        pos        <= pos_next;
        ether_kind <= ether_kind_next;
        flags      <= flags_next;
        sha        <= sha_next;
        gw_mac     <= gw_mac_next;
        gw_known   <= gw_known_next;
        echo_flag  <= echo_flag_next;
      end
      if (accept && end_of_frame)
        out_valid <= 1'b1;
      else if (out_ready)
        out_valid <= 1'b0;
    end
  end

  // the learned state only moves on a final byte, which waits for a free result slot
  always_ff @(posedge clk) begin
    if (accept && end_of_frame)
      kind <= kind_next;
  end

  assign frame_kind         = kind;
  assign gateway_hw_address = gw_mac;
  assign gateway_valid      = gw_known;
  assign echo_seen          = echo_flag;

endmodule

/* design/rxaf_regs.sv */
module rxaf_regs
  import rxaf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_addr   <= LOCAL_RESET;
      cfg.gateway_addr <= GATEWAY_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_LOCAL:   cfg.local_addr   <= pwdata;
        REG_GATEWAY: cfg.gateway_addr <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LOCAL:   prdata = cfg.local_addr;
      REG_GATEWAY: prdata = cfg.gateway_addr;
      default:     prdata = '0;
    endcase
  end

endmodule

/* test/rx_frame_arp_icmp_filter_core_tb.sv */
`timescale 1ns / 100ps

module rx_frame_arp_icmp_filter_core_tb;
  import rxaf_pkg::*;

  typedef struct packed {
    frame_kind_t kind;
    logic [47:0] mac;
    logic        gw_ok;
    logic        echo;
  } verdict_t;

  logic             clk;
  logic             rst;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       rx_byte;
  logic             end_of_frame;
  logic             out_valid;
  logic             out_ready;
  logic [1:0]       frame_kind;
  logic [47:0]      gateway_hw_address;
  logic             gateway_valid;
  logic             echo_seen;

  rx_frame_arp_icmp_filter_core dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .end_of_frame(end_of_frame),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .frame_kind(frame_kind),
    .gateway_hw_address(gateway_hw_address),
    .gateway_valid(gateway_valid),
    .echo_seen(echo_seen)
  );

  // filter state mirrored from the byte stream
  logic [31:0] cfg_local;
  logic [31:0] cfg_gateway;
  logic [5:0]  rx_pos;
  logic [15:0] rx_ethertype;
  logic [7:0]  match_bits;
  logic [47:0] sha_capture;
  logic [47:0] learned_mac;
  logic        learned_ok;
  logic        echo_flag;

  verdict_t    pending_verdicts[$];
  verdict_t    want;
  logic [7:0]  frame_buf[$];

  int  errors = 0;
  int  bytes_sent = 0;
  int  frames_sent = 0;
  int  cfg_writes = 0;
  int  kind_count[3] = '{0, 0, 0};
  int  rx_hold = 0;
  bit  tx_gaps_on = 1'b1;
  bit  rx_stall_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("[rx_frame_arp_icmp_filter_core] ERROR");
    $finish;
  end

  function automatic void reset_filter_state();
    cfg_local   = LOCAL_RESET;
    cfg_gateway = GATEWAY_RESET;
    rx_pos = '0;
    rx_ethertype = '0;
    match_bits = '0;
    sha_capture = '0;
    learned_mac = '0;
    learned_ok = 1'b0;
    echo_flag = 1'b0;
  endfunction

  // Fold one accepted byte into the mirrored state; queue a verdict on the last one.
  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    int unsigned p;
    logic        eq;
    verdict_t    v;
    p = rx_pos;
    if (p < POS_MAX) begin
      case (p)
        OFS_TYPE_HI: rx_ethertype[15:8] = b;
        OFS_TYPE_LO: rx_ethertype[7:0] = b;
        OFS_OP_HI:   match_bits[F_OP_HI] = (b == ARP_OP_HI);
        OFS_OP_LO:   match_bits[F_OP_LO] = (b == ARP_OP_LO);
        OFS_PROTO:   match_bits[F_PROTO] = (b == IP_PROTO_ICMP);
        OFS_ICMP_T:  match_bits[F_ICMP_T] = (b == ICMP_ECHO_REPLY);
        OFS_ID_HI:   match_bits[F_ID_HI] = (b == ECHO_ID_HI);
        OFS_ID_LO:   match_bits[F_ID_LO] = (b == ECHO_ID_LO);
        default: ;
      endcase
      if (p >= OFS_SHA_LO && p <= OFS_SHA_HI) sha_capture = {sha_capture[39:0], b};
      // running four-byte compares: the first byte starts them, later bytes can only clear
      if (p >= OFS_GW_LO && p <= OFS_GW_HI) begin
        eq = (b == 8'(cfg_gateway >> (8 * (OFS_GW_HI - p))));
        if (p == OFS_GW_LO) match_bits[F_GW_IP] = eq;
        else if (!eq) match_bits[F_GW_IP] = 1'b0;
      end
      if (p >= OFS_LOC_LO && p <= OFS_LOC_HI) begin
        eq = (b == 8'(cfg_local >> (8 * (OFS_LOC_HI - p))));
        if (p == OFS_LOC_LO) match_bits[F_LOC_IP] = eq;
        else if (!eq) match_bits[F_LOC_IP] = 1'b0;
      end
      rx_pos = rx_pos + 6'd1;
    end
    if (last) begin
      v.kind = KIND_NONE;
      if (rx_pos >= MIN_FRAME) begin
        if (rx_ethertype == ETYPE_ARP && match_bits[F_OP_HI] && match_bits[F_OP_LO]
            && match_bits[F_GW_IP]) begin
          learned_mac = sha_capture;
          learned_ok = 1'b1;
          v.kind = KIND_ARP_REPLY;
        end else if (rx_ethertype == ETYPE_IPV4 && match_bits[F_PROTO] && match_bits[F_LOC_IP]
                     && match_bits[F_ICMP_T] && match_bits[F_ID_HI] && match_bits[F_ID_LO]) begin
          echo_flag = 1'b1;
          v.kind = KIND_ECHO_REPLY;
        end
      end
      v.mac = learned_mac;
      v.gw_ok = learned_ok;
      v.echo = echo_flag;
      pending_verdicts.push_back(v);
      rx_pos = '0;
      rx_ethertype = '0;
      match_bits = '0;
      sha_capture = '0;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        if (errors < 40)
          $display("%0t: result with none pending, frame_kind %0d", $time, frame_kind);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        kind_count[want.kind]++;
        if (frame_kind !== want.kind || gateway_hw_address !== want.mac
            || gateway_valid !== want.gw_ok || echo_seen !== want.echo) begin
          if (errors < 40) begin
            if (frame_kind !== want.kind)
              $display("%0t: frame_kind expected %0d actual %0d", $time, want.kind, frame_kind);
            if (gateway_hw_address !== want.mac)
              $display("%0t: gateway_hw_address expected %012h actual %012h", $time,
                       want.mac, gateway_hw_address);
            if (gateway_valid !== want.gw_ok)
              $display("%0t: gateway_valid expected %0b actual %0b", $time, want.gw_ok,
                       gateway_valid);
            if (echo_seen !== want.echo)
              $display("%0t: echo_seen expected %0b actual %0b", $time, want.echo, echo_seen);
          end
          errors++;
        end
      end
    end
  end

  // result side: random stalls, plus a long hold-off when one is requested
  initial begin : receiver
    int wait_n;
    out_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      wait_n = rx_stall_on ? $urandom_range(0, 5) : 0;
      wait_n += rx_hold;
      rx_hold = 0;
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    end_of_frame <= last;
    do @(posedge clk); while (!in_ready);
    absorb_byte(b, last);
    bytes_sent++;
    if (last) frames_sent++;
  endtask

  task automatic send_frame(input bit mark);
    int i;
    for (i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], mark && (i == frame_buf.size() - 1));
  endtask

  // drop valid and wait until every verdict has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_cycle(input bit wr, input reg_idx_t idx, input logic [31:0] data,
                           output logic [31:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= AddrW'(4 * idx);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] rd;
    apb_cycle(1'b1, idx, val, rd);
    if (idx == REG_LOCAL) cfg_local = val;
    else cfg_gateway = val;
    cfg_writes++;
    apb_cycle(1'b0, idx, '0, rd);
    if (rd !== val) begin
      $display("%0t: readback of %s expected %08h actual %08h", $time, idx.name(), val, rd);
      errors++;
    end
  endtask

  task automatic set_addresses(input logic [31:0] loc, input logic [31:0] gw);
    settle();
    write_reg(REG_LOCAL, loc);
    write_reg(REG_GATEWAY, gw);
  endtask

  function automatic void fill_random(input int len);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom));
  endfunction

  function automatic void fill_const(input int len, input logic [7:0] v);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(v);
  endfunction

  function automatic void put(input int ofs, input logic [7:0] v);
    if (ofs < frame_buf.size()) frame_buf[ofs] = v;
  endfunction

  function automatic void shape_arp(input logic [31:0] sender_ip, input logic [47:0] mac);
    int i;
    put(OFS_TYPE_HI, ETYPE_ARP[15:8]);
    put(OFS_TYPE_LO, ETYPE_ARP[7:0]);
    put(OFS_OP_HI, ARP_OP_HI);
    put(OFS_OP_LO, ARP_OP_LO);
    for (i = 0; i < 6; i++) put(OFS_SHA_LO + i, mac[47 - 8 * i -: 8]);
    for (i = 0; i < 4; i++) put(OFS_GW_LO + i, sender_ip[31 - 8 * i -: 8]);
  endfunction

  function automatic void shape_echo(input logic [31:0] dst_ip);
    int i;
    put(OFS_TYPE_HI, ETYPE_IPV4[15:8]);
    put(OFS_TYPE_LO, ETYPE_IPV4[7:0]);
    put(OFS_PROTO, IP_PROTO_ICMP);
    for (i = 0; i < 4; i++) put(OFS_LOC_LO + i, dst_ip[31 - 8 * i -: 8]);
    put(OFS_ICMP_T, ICMP_ECHO_REPLY);
    put(OFS_ID_HI, ECHO_ID_HI);
    put(OFS_ID_LO, ECHO_ID_LO);
  endfunction

  // flip one bit of one tested field (spot picks which)
  function automatic void spoil(input bit arp, input int spot);
    int ofs;
    if (arp) begin
      case (spot)
        0:       ofs = OFS_TYPE_HI;
        1:       ofs = OFS_TYPE_LO;
        2:       ofs = OFS_OP_HI;
        3:       ofs = OFS_OP_LO;
        default: ofs = OFS_GW_LO + spot - 4;
      endcase
    end else begin
      case (spot)
        0:       ofs = OFS_TYPE_HI;
        1:       ofs = OFS_TYPE_LO;
        2:       ofs = OFS_PROTO;
        3:       ofs = OFS_ICMP_T;
        4:       ofs = OFS_ID_HI;
        5:       ofs = OFS_ID_LO;
        default: ofs = OFS_LOC_LO + spot - 6;
      endcase
    end
    if (ofs < frame_buf.size()) frame_buf[ofs] ^= 8'(1 << $urandom_range(0, 7));
  endfunction

  function automatic logic [47:0] random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic test_default_addresses();
    fill_random(42);
    shape_arp(GATEWAY_RESET, random_mac());
    send_frame(1'b1);
    fill_random(42);
    shape_echo(LOCAL_RESET);
    send_frame(1'b1);
    fill_random(42);
    shape_arp(GATEWAY_RESET, random_mac());
    put(OFS_OP_LO, 8'h01);  // request, not reply
    send_frame(1'b1);
    settle();
  endtask

  task automatic test_frame_length();
    tx_gaps_on = 1'b0;
    fill_random(41);
    shape_echo(LOCAL_RESET);
    send_frame(1'b1);
    fill_random(1);
    send_frame(1'b1);
    fill_const(64, 8'h00);
    send_frame(1'b1);
    fill_random(66);
    shape_arp(GATEWAY_RESET, random_mac());
    send_frame(1'b1);
    tx_gaps_on = 1'b1;
    settle();
  endtask

  // a frame whose end mark comes only after a pause must still classify as one frame
  task automatic test_split_frame();
    logic [7:0] whole[$];
    int i;
    fill_random(48);
    shape_arp(cfg_gateway, random_mac());
    whole = frame_buf;
    frame_buf = whole[0:24];
    send_frame(1'b0);
    settle();
    frame_buf.delete();
    for (i = 25; i < whole.size(); i++) frame_buf.push_back(whole[i]);
    send_frame(1'b1);
    settle();
  endtask

  task automatic test_near_misses();
    fill_random(42); shape_arp(cfg_gateway, random_mac()); spoil(1'b1, 5); send_frame(1'b1);
    fill_random(42); shape_echo(cfg_local); spoil(1'b0, 9); send_frame(1'b1);
    // overlapping fields: gateway octets 2,3 equal local octets 0,1, so both sets can pass
    set_addresses(32'h0101_2A2B, 32'hC0A8_0101);
    fill_random(42); shape_arp(cfg_gateway, random_mac()); shape_echo(cfg_local);
    send_frame(1'b1);
    put(OFS_TYPE_HI, ETYPE_IPV4[15:8]); put(OFS_TYPE_LO, ETYPE_IPV4[7:0]);
    send_frame(1'b1);
    settle();
  endtask

  task automatic test_address_extremes();
    set_addresses('0, '1);
    fill_random(42); shape_arp('1, random_mac()); send_frame(1'b1);
    fill_random(42); shape_echo('0); send_frame(1'b1);
    settle();
  endtask

  // hold results off for a long stretch while back-to-back frames keep coming
  task automatic test_backpressure();
    int i;
    tx_gaps_on = 1'b0;
    rx_hold = 150;
    for (i = 0; i < 20; i++) begin
      fill_random($urandom_range(1, 3));
      send_frame(1'b1);
    end
    fill_random(42); shape_echo(cfg_local); send_frame(1'b1);
    tx_gaps_on = 1'b1;
    settle();
  endtask

  task automatic new_addresses();
    logic [31:0] a;
    logic [31:0] g;
    case ($urandom_range(0, 5))
      0:       begin a = LOCAL_RESET; g = GATEWAY_RESET; end
      1:       begin a = '0; g = '1; end
      2:       begin a = '1; g = '0; end
      3:       begin a = $urandom; g = a; end
      default: begin a = $urandom; g = $urandom; end
    endcase
    set_addresses(a, g);
  endtask

  function automatic int frame_len();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(64, 90) : $urandom_range(42, 63);
  endfunction

  function automatic logic [31:0] pick_ip(input logic [31:0] likely);
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return cfg_local ^ cfg_gateway ^ likely;
      default: return likely;
    endcase
  endfunction

  task automatic test_random_traffic();
    int frames;
    frames = 0;
    while (bytes_sent < 740 || frames < 2) begin
      if (frames % 2 == 0) begin
        new_addresses();
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_stall_on = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          fill_random(frame_len());
          shape_arp(pick_ip(cfg_gateway), random_mac());
          if ($urandom_range(0, 3) == 0) spoil(1'b1, $urandom_range(0, 7));
        end
        4, 5, 6: begin
          fill_random(frame_len());
          shape_echo(pick_ip(cfg_local));
          if ($urandom_range(0, 3) == 0) spoil(1'b0, $urandom_range(0, 9));
        end
        7: fill_random($urandom_range(1, 70));
        8: begin
          fill_random($urandom_range(1, 41));
          if ($urandom_range(0, 1)) shape_arp(cfg_gateway, random_mac());
          else shape_echo(cfg_local);
        end
        default: begin
          // unterminated stub that runs into the next frame, shifting its offsets
          fill_random($urandom_range(1, 20));
          send_frame(1'b0);
          fill_random(frame_len());
          shape_echo(cfg_local);
        end
      endcase
      send_frame(1'b1);
      frames++;
    end
    rx_stall_on = 1'b1;
    settle();
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    rx_byte <= '0;
    end_of_frame <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    reset_filter_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_addresses();
    test_frame_length();
    test_split_frame();
    test_near_misses();
    test_address_extremes();
    test_backpressure();
    test_random_traffic();

    settle();
    repeat (10) @(posedge clk);
    $display("Sent %0d frames in %0d bytes: %0d ignored, %0d gateway ARP, %0d echo replies",
             frames_sent, bytes_sent, kind_count[KIND_NONE], kind_count[KIND_ARP_REPLY],
             kind_count[KIND_ECHO_REPLY]);
    $display("Address registers written %0d times; gaps, stalls and a long result hold-off",
             cfg_writes);
    if (errors == 0) begin
      $display("[rx_frame_arp_icmp_filter_core] OK");
    end else begin
      $display("[rx_frame_arp_icmp_filter_core] ERROR");
    end
    $finish;
  end

endmodule
